@@ src/rpa_pkg.sv @@
// Shared constants and types for the reference-counted page allocator.
`default_nettype none

package rpa_pkg;

    // Default sizing of the allocator.
    localparam int NUM_PAGES_DEF = 4096;
    localparam int REF_WIDTH_DEF = 8;

    // Fixed field widths on the streams.
    localparam int ACT_W   = 3;
    localparam int PAGE_W  = 12;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 13;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 32;

    // Request actions.
    localparam logic [ACT_W-1:0] ACT_INIT    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ALLOC   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ADDREF  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 3'd1;
    localparam logic [STAT_W-1:0] ST_ZERO  = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd3;
    localparam logic [STAT_W-1:0] ST_SAT   = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_EXEC
    } t_state;

endpackage

`default_nettype wire

@@ src/rpa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/refcounted_page_allocator.sv @@
// Reference-counted physical page allocator with a refcount RAM and a free-page stack RAM.
//
// Requests enter on the slave stream: tdata holds the action (init, alloc, release,
// addref, query) and a page index. Each request gives exactly one result on the
// master stream: allocated page, status, page-freed flag and free count.
// The single configuration register, first_free_page, is written through i_cfg_we.
//
// Alloc, release, addref and query: the accept edge issues one read of the refcount
// RAM and one of the stack RAM, and the write-back state then writes the updated
// entry back and loads the result register. Init walks every page, one refcount
// clear and at most one stack push per cycle.
//
// After reset the block runs a clearing pass over every entry of the
// refcount RAM with tready low; the free stack starts empty.
// A request can be accepted while the previous result still waits on the
// master side; the block then holds the new request's write-back until the
// receiver takes the old result.
`default_nettype none

module refcounted_page_allocator #(
    parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEF,
    parameter int REF_WIDTH = rpa_pkg::REF_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Request stream: [2:0] action, [14:3] page_index, [15] zero.
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic [rpa_pkg::IN_W-1:0]   i_s_axis_tdata,
    // Result stream: [11:0] alloc_page, [14:12] status, [15] page_freed,
    // [28:16] free_count, [31:29] zero.
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    output logic      [rpa_pkg::OUT_W-1:0]  o_m_axis_tdata,
    // Configuration: first_free_page.
    input  wire logic                       i_cfg_we,
    input  wire logic [rpa_pkg::PAGE_W-1:0] i_cfg_wdata
);

    import rpa_pkg::*;

    localparam int PG_W  = $clog2(NUM_PAGES);
    localparam int CNT_W = $clog2(NUM_PAGES + 1);
    localparam int WIDE  = CNT_W + PAGE_W;

    t_state              r_state, n_state;
    logic [PG_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_depth, n_depth;
    logic [PAGE_W-1:0]   r_first_free;
    logic [ACT_W-1:0]    r_action, n_action;
    logic [PAGE_W-1:0]   r_pg, n_pg;

    logic                r_out_valid, n_out_valid;
    logic [PAGE_W-1:0]   r_out_page, n_out_page;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    logic                r_out_freed, n_out_freed;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic                ref_we, ref_re;
    logic [PG_W-1:0]     ref_waddr, ref_raddr;
    logic [REF_WIDTH-1:0] ref_wdata, ref_rdata;
    logic                stk_we, stk_re;
    logic [PG_W-1:0]     stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    logic                accept, out_free, page_ok, stack_full;
    logic [ACT_W-1:0]    in_action;
    logic [PAGE_W-1:0]   in_pg;

    assign in_action  = i_s_axis_tdata[ACT_W-1:0];
    assign in_pg      = i_s_axis_tdata[ACT_W +: PAGE_W];
    assign accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign page_ok    = (WIDE'(r_pg) >= WIDE'(r_first_free)) &&
                        (WIDE'(r_pg) < WIDE'(NUM_PAGES));
    assign stack_full = (r_depth >= CNT_W'(NUM_PAGES));

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_count, r_out_freed, r_out_status, r_out_page};

    // Both RAMs are read only at the accept edge; the data then stays put
    // through any stall in the write-back state.
    assign ref_re    = accept;
    assign ref_raddr = PG_W'(in_pg);
    assign stk_re    = accept;
    assign stk_raddr = PG_W'(r_depth - CNT_W'(1));

    rpa_ram #(
        .WIDTH (REF_WIDTH),
        .DEPTH (NUM_PAGES)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (ref_wdata),
        .i_re    (ref_re),
        .i_raddr (ref_raddr),
        .o_rdata (ref_rdata)
    );

    rpa_ram #(
        .WIDTH (PG_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cnt        <= '0;
            r_depth      <= '0;
            r_first_free <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_first_free <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_pg         <= n_pg;
        r_out_page   <= n_out_page;
        r_out_status <= n_out_status;
        r_out_freed  <= n_out_freed;
        r_out_count  <= n_out_count;
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_depth      = r_depth;
        n_action     = r_action;
        n_pg         = r_pg;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_page   = r_out_page;
        n_out_status = r_out_status;
        n_out_freed  = r_out_freed;
        n_out_count  = r_out_count;
        ref_we       = 1'b0;
        ref_waddr    = r_cnt;
        ref_wdata    = '0;
        stk_we       = 1'b0;
        stk_waddr    = PG_W'(r_depth);
        stk_wdata    = r_cnt;

        unique case (r_state)
            S_CLEAR: begin
                ref_we = 1'b1;
                n_cnt  = r_cnt + PG_W'(1);
                if (r_cnt == PG_W'(NUM_PAGES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_action = in_action;
                    n_pg     = in_pg;
                    n_cnt    = '0;
                    if (in_action == ACT_INIT) begin
                        n_depth = '0;
                        n_state = S_INIT;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end

            S_INIT: begin
                // Clear one refcount and push the page if it is above the kernel image.
                ref_we = 1'b1;
                if (WIDE'(r_cnt) >= WIDE'(r_first_free)) begin
                    stk_we  = 1'b1;
                    n_depth = r_depth + CNT_W'(1);
                end
                n_cnt = r_cnt + PG_W'(1);
                if (r_cnt == PG_W'(NUM_PAGES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_page   = '0;
                    n_out_status = ST_OK;
                    n_out_freed  = 1'b0;
                    n_state      = S_IDLE;
                    unique case (r_action)
                        ACT_ALLOC: begin
                            if (r_depth == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_depth    = r_depth - CNT_W'(1);
                                ref_we     = 1'b1;
                                ref_waddr  = stk_rdata;
                                ref_wdata  = REF_WIDTH'(1);
                                n_out_page = PAGE_W'(stk_rdata);
                            end
                        end
                        ACT_RELEASE: begin
                            ref_waddr = PG_W'(r_pg);
                            if (!page_ok) begin
                                n_out_status = ST_RANGE;
                            end else if (ref_rdata == '0) begin
                                n_out_status = ST_ZERO;
                            end else begin
                                ref_we    = 1'b1;
                                ref_wdata = ref_rdata - REF_WIDTH'(1);
                                if (ref_rdata == REF_WIDTH'(1) && !stack_full) begin
                                    stk_we      = 1'b1;
                                    stk_wdata   = PG_W'(r_pg);
                                    n_depth     = r_depth + CNT_W'(1);
                                    n_out_freed = 1'b1;
                                end
                            end
                        end
                        ACT_ADDREF: begin
                            ref_waddr = PG_W'(r_pg);
                            if (!page_ok) begin
                                n_out_status = ST_RANGE;
                            end else if (ref_rdata == '0) begin
                                n_out_status = ST_ZERO;
                            end else if (ref_rdata == '1) begin
                                n_out_status = ST_SAT;
                            end else begin
                                ref_we    = 1'b1;
                                ref_wdata = ref_rdata + REF_WIDTH'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_count = COUNT_W'(n_depth);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The stack never holds more pages than exist.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CNT_W'(NUM_PAGES))
        else $error("free stack depth beyond page count");

    // An accepted request always leaves the idle state for its work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_INIT || r_state == S_EXEC))
        else $error("accepted request did not start");

    // No write-back while the previous result is still stalled.
    a_stall_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_out_valid && !i_m_axis_tready) |-> (!ref_we && !stk_we))
        else $error("memory written while result stalled");

    // A request in write-back moves the stack depth by at most one page.
    a_depth_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_depth == $past(r_depth) ||
                                 r_depth == $past(r_depth) + CNT_W'(1) ||
                                 r_depth == $past(r_depth) - CNT_W'(1)))
        else $error("stack depth jumped by more than one");

endmodule

`default_nettype wire

@@ tb/tb_refcounted_page_allocator.sv @@
// Self-checking testbench for the reference-counted page allocator.
`timescale 1ns / 100ps

module tb_refcounted_page_allocator;
    import rpa_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam logic [REF_WIDTH_DEF-1:0] REF_MAX = '1;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [STAT_W-1:0]  status;
        logic               freed;
        logic [COUNT_W-1:0] count;
    } t_alloc_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [IN_W-1:0]    s_tdata = '0;
    logic               m_tready = 1'b0;
    logic               cfg_we = 1'b0;
    logic [PAGE_W-1:0]  cfg_wdata = '0;
    wire                o_s_axis_tready;
    wire                o_m_axis_tvalid;
    wire [OUT_W-1:0]    o_m_axis_tdata;

    // Shadow copy of the allocator state.
    logic [REF_WIDTH_DEF-1:0] page_refs [NUM_PAGES_DEF];
    logic [PAGE_W-1:0]        stack_model [NUM_PAGES_DEF];
    logic [COUNT_W-1:0]       free_depth = '0;
    logic [PAGE_W-1:0]        first_free_pg = '0;
    logic [PAGE_W-1:0]        owned_pages [$];

    logic [IN_W-1:0] pending_requests [$];
    t_alloc_result   expected_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int requests_taken = 0;
    int results_seen = 0;
    int hold_left = 0;
    int hold_mark = 100;
    int quiet_cycles = 0;
    int n_errors = 0;

    refcounted_page_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        foreach (page_refs[i]) page_refs[i] = '0;
        foreach (stack_model[i]) stack_model[i] = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        n_errors++;
    endtask

    function automatic t_alloc_result allocator_step(input logic [IN_W-1:0] req);
        logic [ACT_W-1:0]  act;
        logic [PAGE_W-1:0] pg;
        t_alloc_result     res;
        int                p;
        int                idx;
        act = req[ACT_W-1:0];
        pg  = req[ACT_W +: PAGE_W];
        res = '0;
        idx = -1;
        case (act)
            ACT_INIT: begin
                for (p = 0; p < NUM_PAGES_DEF; p++) page_refs[p] = '0;
                free_depth = '0;
                owned_pages.delete();
                for (p = int'(first_free_pg); p < NUM_PAGES_DEF; p++) begin
                    stack_model[free_depth] = p[PAGE_W-1:0];
                    free_depth = free_depth + 1'b1;
                end
            end
            ACT_ALLOC: begin
                if (free_depth == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    free_depth = free_depth - 1'b1;
                    res.page = stack_model[free_depth];
                    page_refs[res.page] = REF_WIDTH_DEF'(1);
                    owned_pages.push_back(res.page);
                end
            end
            ACT_RELEASE: begin
                if (pg < first_free_pg) begin
                    res.status = ST_RANGE;
                end else if (page_refs[pg] == 0) begin
                    res.status = ST_ZERO;
                end else begin
                    page_refs[pg] = page_refs[pg] - 1'b1;
                    // The stack cannot overflow while the counts stay consistent.
                    if (page_refs[pg] == 0 && free_depth < NUM_PAGES_DEF) begin
                        stack_model[free_depth] = pg;
                        free_depth = free_depth + 1'b1;
                        res.freed = 1'b1;
                        foreach (owned_pages[i]) if (owned_pages[i] == pg) idx = i;
                        if (idx >= 0) owned_pages.delete(idx);
                    end
                end
            end
            ACT_ADDREF: begin
                if (pg < first_free_pg) begin
                    res.status = ST_RANGE;
                end else if (page_refs[pg] == 0) begin
                    res.status = ST_ZERO;
                end else if (page_refs[pg] == REF_MAX) begin
                    res.status = ST_SAT;
                end else begin
                    page_refs[pg] = page_refs[pg] + 1'b1;
                end
            end
            default: ;
        endcase
        res.count = free_depth;
        return res;
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                expected_results.push_back(allocator_step(s_tdata));
                requests_taken <= requests_taken + 1;
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_requests.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs so that the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_mark <= 100;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (requests_taken >= hold_mark) begin
            hold_left <= 64;
            hold_mark <= hold_mark + 500;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_alloc_result want;
        logic [PAGE_W-1:0]  got_page;
        logic [STAT_W-1:0]  got_status;
        logic               got_freed;
        logic [COUNT_W-1:0] got_count;
        got_page   = o_m_axis_tdata[11:0];
        got_status = o_m_axis_tdata[14:12];
        got_freed  = o_m_axis_tdata[15];
        got_count  = o_m_axis_tdata[28:16];
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
            if (o_m_axis_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                        results_seen));
                end else begin
                    want = expected_results.pop_front();
                    if (got_page !== want.page)
                        report_mismatch($sformatf("result %0d alloc_page %0d, expected %0d",
                            results_seen, got_page, want.page));
                    if (got_status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                            results_seen, got_status, want.status));
                    if (got_freed !== want.freed)
                        report_mismatch($sformatf("result %0d page_freed %0b, expected %0b",
                            results_seen, got_freed, want.freed));
                    if (got_count !== want.count)
                        report_mismatch($sformatf("result %0d free_count %0d, expected %0d",
                            results_seen, got_count, want.count));
                end
                results_seen <= results_seen + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("refcounted_page_allocator verification failed");
            $finish;
        end
    end

    task automatic queue_request(input logic [ACT_W-1:0] act, input logic [PAGE_W-1:0] pg);
        @(negedge i_clk);
        while (pending_requests.size() >= 2) @(negedge i_clk);
        pending_requests.push_back({1'b0, pg, act});
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic program_first_free(input logic [PAGE_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        first_free_pg = value;
    endtask

    function automatic logic [PAGE_W-1:0] pick_owned_page();
        if (owned_pages.size() == 0)
            return PAGE_W'($urandom_range(0, NUM_PAGES_DEF - 1));
        return owned_pages[$urandom_range(0, owned_pages.size() - 1)];
    endfunction

    // Mostly well-formed traffic: allocations, then releases and extra
    // references on pages that are actually held, with some noise mixed in.
    task automatic run_random(input int n_items);
        int                issued;
        int                pick;
        int                burst;
        logic [PAGE_W-1:0] pg;
        issued = 0;
        while (issued < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                queue_request(ACT_INIT, PAGE_W'($urandom));
                issued++;
            end else if (pick < 35) begin
                burst = $urandom_range(1, 6);
                repeat (burst) queue_request(ACT_ALLOC, PAGE_W'($urandom));
                issued += burst;
            end else if (pick < 65) begin
                burst = $urandom_range(1, 3);
                pg = pick_owned_page();
                repeat (burst) queue_request(ACT_RELEASE, pg);
                issued += burst;
            end else if (pick < 80) begin
                burst = $urandom_range(1, 4);
                pg = pick_owned_page();
                repeat (burst) queue_request(ACT_ADDREF, pg);
                issued += burst;
            end else if (pick < 85) begin
                queue_request(ACT_QUERY, PAGE_W'($urandom));
                issued++;
            end else begin
                queue_request(ACT_W'($urandom_range(0, 7)), PAGE_W'($urandom));
                issued++;
            end
        end
    endtask

    initial begin
        logic [PAGE_W-1:0] pg;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Only the top page is usable: empty stack, range and zero-count errors.
        program_first_free(12'd4095);
        queue_request(ACT_ALLOC, 12'd0);
        queue_request(ACT_QUERY, 12'd4095);
        queue_request(ACT_RELEASE, 12'd0);
        queue_request(ACT_ADDREF, 12'd4094);
        queue_request(ACT_ADDREF, 12'd4095);
        queue_request(ACT_RELEASE, 12'd4095);
        queue_request(ACT_INIT, 12'd0);
        queue_request(ACT_ALLOC, 12'd0);
        queue_request(ACT_ALLOC, 12'd4095);
        queue_request(ACT_ADDREF, 12'd4095);
        queue_request(ACT_RELEASE, 12'd4095);
        queue_request(ACT_RELEASE, 12'd4095);
        queue_request(3'd5, 12'd4095);
        queue_request(3'd6, 12'hAAA);
        queue_request(3'd7, 12'h555);

        // Whole page range usable.
        program_first_free(12'd0);
        queue_request(ACT_INIT, 12'd4095);
        queue_request(ACT_ALLOC, 12'd0);
        queue_request(ACT_RELEASE, 12'd0);
        queue_request(ACT_ADDREF, 12'd4095);
        queue_request(ACT_ALLOC, 12'd0);
        queue_request(ACT_RELEASE, 12'd4094);
        queue_request(ACT_QUERY, 12'd0);
        queue_request(ACT_ALLOC, 12'd0);

        program_first_free(PAGE_W'($urandom));
        send_idle_pct = 20;
        recv_idle_pct = 80;
        queue_request(ACT_INIT, 12'd0);
        run_random(350);

        program_first_free(PAGE_W'($urandom_range(0, 63)));
        send_idle_pct = 80;
        recv_idle_pct = 20;
        queue_request(ACT_INIT, 12'd0);
        run_random(350);

        // Few pages, so the stack runs empty often; one page is driven to
        // the refcount ceiling and past it.
        program_first_free(PAGE_W'($urandom_range(4032, 4095)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_request(ACT_INIT, 12'd0);
        queue_request(ACT_ALLOC, 12'd0);
        wait_drained();
        pg = pick_owned_page();
        repeat (256) queue_request(ACT_ADDREF, pg);
        repeat (2) queue_request(ACT_RELEASE, pg);
        run_random(250);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (n_errors == 0)
            $display("refcounted_page_allocator verification clean");
        else
            $display("refcounted_page_allocator verification failed");
        $finish;
    end

endmodule
